FILE: sv/assert_macros.svh
// Assertion macros used by the checker file alist_chk.sv.
// No dependencies; take in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is low.
`define ALIST_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ALIST_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/alist_pkg.sv
// Shared constants for the array list engine: field widths, defaults,
// command and status codes. No dependencies.
package alist_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W     = 4;
    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;

    localparam logic [CMD_W-1:0] CMD_PUSH      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_POP       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_UPDATE    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_READ      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_FRONT     = 4'd6;
    localparam logic [CMD_W-1:0] CMD_BACK      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_FINDFIRST = 4'd8;
    localparam logic [CMD_W-1:0] CMD_FINDLAST  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_DELEQUAL  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_FILL      = 4'd11;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd12;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

endpackage

FILE: sv/array_list_engine.sv
// Array list engine: bounded ordered element store with a count.
// Uses alist_pkg and one alist_ram instance for the element store.
//
// Input channel (i_in_valid / o_in_ready) carries one request: command,
// position and value. Output channel (o_out_valid / i_out_ready) returns
// one result per request: status, read value, find result and count.
// One request is worked on at a time; o_in_ready is high only while idle.
// Each request passes from idle through a walk state, which reads and
// writes the RAM, to a final state that loads the result. Elements walked:
//   push, pop, update, clear, failed commands, unused codes: none.
//   read, front, back: one element read; insert: count - position elements;
//   delete: count - position - 1; find first / last: elements read up to the
//   match, at most count; delete-equal and fill: count elements.
// The next request is taken only after the result is loaded, so a new
//   request is never taken before the last is done; the walk moves one
//   element per cycle through the RAM ports.
// Reset (synchronous, active low) empties the store; no clearing pass runs.
// A stalled result waits in the output register; the engine still takes and
// works one new request and holds its result until the register frees.
module array_list_engine import alist_pkg::*; #(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [POS_W-1:0]     i_position_in,
    input  logic [VAL_W-1:0]     i_value_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [STAT_W-1:0]    o_status,
    output logic [VAL_W-1:0]     o_value_out,
    output logic                 o_found,
    output logic [POS_W-1:0]     o_found_position,
    output logic [CNT_OUT_W-1:0] o_count_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CMD_W-1:0]      r_cmd;
    logic [AW-1:0]         r_pos;
    logic [DATA_WIDTH-1:0] r_val;
    logic [STAT_W-1:0]     r_stat, n_stat;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [CW-1:0]         r_left, n_left;
    logic                  r_down, n_down;
    logic                  r_dv;
    logic [AW-1:0]         r_daddr;
    logic [CW-1:0]         r_j;
    logic                  r_hit;
    logic [AW-1:0]         r_hitpos;
    logic [DATA_WIDTH-1:0] r_rd;

    logic                  r_ov;
    logic [STAT_W-1:0]     r_o_status;
    logic [VAL_W-1:0]      r_o_value;
    logic                  r_o_found;
    logic [POS_W-1:0]      r_o_fpos;
    logic [CNT_OUT_W-1:0]  r_o_count;

    logic                  w_accept;
    logic [XW-1:0]         w_pos_x, w_n_x, w_cap_x;
    logic [63:0]           w_val64, w_rd64;
    logic [DATA_WIDTH-1:0] w_val;
    logic [AW-1:0]         w_last;
    logic                  w_empty, w_full;

    logic [DATA_WIDTH-1:0] w_rdata;
    logic                  w_match, w_is_find, w_is_fill, w_is_rd, w_hit_now;
    logic                  w_re, w_fill_we, w_go_fin, w_out_free, w_fin_go;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic [15:0]           w_hp16, w_cnt16;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_pos_x  = XW'(i_position_in);
    assign w_n_x    = XW'(r_count);
    assign w_cap_x  = XW'(CAPACITY);
    assign w_val64  = 64'(i_value_in);
    assign w_val    = w_val64[DATA_WIDTH-1:0];
    assign w_last   = AW'(r_count - CW'(1));
    assign w_empty  = (r_count == '0);
    assign w_full   = (w_n_x >= w_cap_x);

    // Check the request and set up the walk at accept time.
    always_comb begin
        n_stat = ST_OK;
        n_ptr  = '0;
        n_left = '0;
        n_down = 1'b0;
        case (i_command)
            CMD_PUSH: begin
                if (w_full) n_stat = ST_FULL;
            end
            CMD_POP: begin
                if (w_empty) n_stat = ST_EMPTY;
            end
            CMD_INSERT: begin
                if (w_pos_x > w_n_x) n_stat = ST_RANGE;
                else if (w_full) n_stat = ST_FULL;
                n_ptr  = w_last;
                n_left = CW'(w_n_x - w_pos_x);
                n_down = 1'b1;
            end
            CMD_DELETE: begin
                if (w_pos_x >= w_n_x) n_stat = ST_RANGE;
                n_ptr  = AW'(w_pos_x + XW'(1));
                n_left = CW'(w_n_x - w_pos_x - XW'(1));
            end
            CMD_UPDATE: begin
                if (w_pos_x >= w_n_x) n_stat = ST_RANGE;
            end
            CMD_READ: begin
                if (w_pos_x >= w_n_x) n_stat = ST_RANGE;
                n_ptr  = AW'(w_pos_x);
                n_left = CW'(1);
            end
            CMD_FRONT: begin
                if (w_empty) n_stat = ST_EMPTY;
                n_left = CW'(1);
            end
            CMD_BACK: begin
                if (w_empty) n_stat = ST_EMPTY;
                n_ptr  = w_last;
                n_left = CW'(1);
            end
            CMD_FINDFIRST, CMD_DELEQUAL, CMD_FILL: begin
                n_left = r_count;
            end
            CMD_FINDLAST: begin
                n_ptr  = w_last;
                n_left = r_count;
                n_down = 1'b1;
            end
            default: begin
            end
        endcase
        if (n_stat != ST_OK) begin
            n_left = '0;
        end
    end

    assign w_match    = (w_rdata == r_val);
    assign w_is_find  = (r_cmd == CMD_FINDFIRST) || (r_cmd == CMD_FINDLAST);
    assign w_is_fill  = (r_cmd == CMD_FILL);
    assign w_is_rd    = (r_cmd == CMD_READ) || (r_cmd == CMD_FRONT) || (r_cmd == CMD_BACK);
    assign w_hit_now  = r_dv && w_is_find && !r_hit && w_match;
    assign w_re       = (r_state == S_WALK) && (r_left != '0) && !w_is_fill
                        && !r_hit && !w_hit_now;
    assign w_fill_we  = (r_state == S_WALK) && w_is_fill && (r_left != '0);
    assign w_go_fin   = !w_re && (!w_is_fill || (r_left <= CW'(1)));
    assign w_out_free = !r_ov || i_out_ready;
    assign w_fin_go   = (r_state == S_FIN) && w_out_free;

    // Single write port: walk writes back shifted or kept data or the fill value,
    // the final step writes the new element.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = r_val;
        if (r_state == S_WALK) begin
            case (r_cmd)
                CMD_FILL: begin
                    w_we = w_fill_we;
                end
                CMD_INSERT: begin
                    w_we    = r_dv;
                    w_waddr = r_daddr + AW'(1);
                    w_wdata = w_rdata;
                end
                CMD_DELETE: begin
                    w_we    = r_dv;
                    w_waddr = r_daddr - AW'(1);
                    w_wdata = w_rdata;
                end
                CMD_DELEQUAL: begin
                    w_we    = r_dv && !w_match;
                    w_waddr = AW'(r_j);
                    w_wdata = w_rdata;
                end
                default: begin
                end
            endcase
        end else if (w_fin_go && (r_stat == ST_OK)) begin
            case (r_cmd)
                CMD_PUSH: begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_count);
                end
                CMD_INSERT, CMD_UPDATE: begin
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_fin_go && (r_stat == ST_OK)) begin
            case (r_cmd)
                CMD_PUSH, CMD_INSERT: n_count = r_count + CW'(1);
                CMD_POP, CMD_DELETE:  n_count = r_count - CW'(1);
                CMD_DELEQUAL:         n_count = r_j;
                CMD_CLEAR:            n_count = '0;
                default:              n_count = r_count;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept) n_state = S_WALK;
            S_WALK: if (w_go_fin) n_state = S_FIN;
            S_FIN:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    alist_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_left  <= '0;
            r_hit   <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= w_re;
            if (w_accept) begin
                r_left <= n_left;
                r_hit  <= 1'b0;
            end else begin
                if (w_re || w_fill_we) r_left <= r_left - CW'(1);
                if (w_hit_now) r_hit <= 1'b1;
            end
            if (w_fin_go) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    // Payload and walk bookkeeping.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_command;
            r_pos    <= AW'(i_position_in);
            r_val    <= w_val;
            r_stat   <= n_stat;
            r_ptr    <= n_ptr;
            r_down   <= n_down;
            r_j      <= '0;
            r_hitpos <= '0;
            r_rd     <= '0;
        end else begin
            if (w_re || w_fill_we) r_ptr <= r_down ? r_ptr - AW'(1) : r_ptr + AW'(1);
            if (r_dv && w_is_rd) r_rd <= w_rdata;
            if (w_hit_now) r_hitpos <= r_daddr;
            if (r_dv && (r_cmd == CMD_DELEQUAL) && !w_match) r_j <= r_j + CW'(1);
        end
        r_daddr <= r_ptr;
    end

    assign w_rd64  = 64'(r_rd);
    assign w_hp16  = 16'(r_hitpos);
    assign w_cnt16 = 16'(n_count);

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_o_status <= r_stat;
            r_o_value  <= w_rd64[VAL_W-1:0];
            r_o_found  <= r_hit;
            r_o_fpos   <= w_hp16[POS_W-1:0];
            r_o_count  <= w_cnt16[CNT_OUT_W-1:0];
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_ov;
    assign o_status         = r_o_status;
    assign o_value_out      = r_o_value;
    assign o_found          = r_o_found;
    assign o_found_position = r_o_fpos;
    assign o_count_out      = r_o_count;

endmodule

FILE: sv/alist_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module alist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/alist_chk.sv
// Port-level checker for the array list engine, bound to the top level.
// Uses alist_pkg and assert_macros.svh.
`include "assert_macros.svh"

module alist_chk import alist_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [STAT_W-1:0]    o_status,
    input logic [VAL_W-1:0]     o_value_out,
    input logic                 o_found,
    input logic [POS_W-1:0]     o_found_position,
    input logic [CNT_OUT_W-1:0] o_count_out
);

    // Reset drops any pending result.
    `ALIST_ASSERT_RST(a_reset_clears, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // A stalled result holds its status, value and count.
    `ALIST_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_value_out) && $stable(o_count_out), "stalled result changed")

    // One request in flight: busy right after an accept.
    `ALIST_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "request taken while busy")

    // A failed request reports no data and no match.
    `ALIST_ASSERT(a_fail_no_data, i_clk, i_rst_n, o_out_valid && o_status != ST_OK |-> o_value_out == '0 && !o_found && o_found_position == '0, "failed request carries data")

endmodule

bind array_list_engine alist_chk u_alist_chk (.*);
